>>> sv/dtfp_pkg.sv
// types and constants shared by the decimal text to fixed point parser
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_NAN  = 3'd1,
        MODE_SIGN = 3'd2,
        MODE_INT  = 3'd3,
        MODE_FRAC = 3'd4
    } token_mode_t;

    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam int COUNT_W = 16;
    localparam int DIGIT_CNT_W = 4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]  value;
        logic                is_nan;
        logic [COUNT_W-1:0]  row;
        logic [COUNT_W-1:0]  column;
        logic                last_in_line;
        logic                short_line;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/dtfp_apply.sv
// token update for one text byte: acceptance tests and the accumulate step
`timescale 1ns / 1ps
`default_nettype none

module dtfp_apply #(
    parameter int INT_BITS = 16,
    parameter int FRAC_BITS = 16,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  dtfp_pkg::token_mode_t              cur_mode,
    input  logic                               cur_negative,
    input  logic [INT_BITS-1:0]                cur_int,
    input  logic [FRAC_BITS+3:0]               cur_frac,
    input  logic [dtfp_pkg::DIGIT_CNT_W-1:0]   cur_digits,
    input  logic [7:0]                         text_byte,
    output logic                               cont,
    output logic                               start,
    output dtfp_pkg::token_mode_t              new_mode,
    output logic                               new_negative,
    output logic [INT_BITS-1:0]                new_int,
    output logic [FRAC_BITS+3:0]               new_frac,
    output logic [dtfp_pkg::DIGIT_CNT_W-1:0]   new_digits
);
    import dtfp_pkg::*;

    localparam int IW = INT_BITS + 4;
    localparam int FW = FRAC_BITS + 4;
    localparam int TAB_N = 2 ** DIGIT_CNT_W;
    localparam logic [IW-1:0] INT_CAP = IW'(1) << (INT_BITS - 1);
    localparam logic [DIGIT_CNT_W-1:0] MAX_DIGITS = DIGIT_CNT_W'(MAX_FRAC_DIGITS);

    // weight of fraction digit i: 2^FRAC_BITS / 10^i rounded half up
    logic [FRAC_BITS-1:0] weight [TAB_N];

    for (genvar gi = 0; gi < TAB_N; gi++)
    begin : g_weight
        localparam logic [63:0] POW = 64'd10 ** gi;
        localparam logic [63:0] WEIGHT = ((64'd1 << (FRAC_BITS + 1)) + POW) / (64'd2 * POW);
        assign weight[gi] = WEIGHT[FRAC_BITS-1:0];
    end

    logic                     is_digit;
    logic [3:0]               digit;
    logic                     use_cur;
    token_mode_t              base_mode;
    logic                     base_negative;
    logic [INT_BITS-1:0]      base_int;
    logic [FW-1:0]            base_frac;
    logic [DIGIT_CNT_W-1:0]   base_digits;
    logic [IW-1:0]            int_wide;
    logic [DIGIT_CNT_W-1:0]   weight_idx;
    logic [FW-1:0]            frac_add;

    always_comb
    begin
        is_digit = text_byte inside {[CHAR_ZERO:CHAR_NINE]};
        digit = text_byte[3:0];

        case (cur_mode)
            MODE_NAN:
                cont = (text_byte == CHAR_N) || (text_byte == CHAR_LOWER_A);
            MODE_SIGN, MODE_INT:
                cont = is_digit || (text_byte == CHAR_DOT);
            MODE_FRAC:
                cont = is_digit;
            default:
                cont = 1'b0;
        endcase
        start = is_digit || (text_byte inside {CHAR_DOT, CHAR_MINUS, CHAR_N});

        // continue the current token, or start one from a clear token
        use_cur = cont;
        base_mode = use_cur ? cur_mode : MODE_IDLE;
        base_negative = use_cur ? cur_negative : 1'b0;
        base_int = use_cur ? cur_int : '0;
        base_frac = use_cur ? cur_frac : '0;
        base_digits = use_cur ? cur_digits : '0;

        int_wide = (IW'(base_int) << 3) + (IW'(base_int) << 1) + IW'(digit);
        weight_idx = base_digits + DIGIT_CNT_W'(1);
        frac_add = FW'(digit) * FW'(weight[weight_idx]);

        new_mode = base_mode;
        new_negative = base_negative;
        new_int = base_int;
        new_frac = base_frac;
        new_digits = base_digits;

        if (is_digit)
        begin
            if (base_mode == MODE_FRAC)
            begin
                if (base_digits < MAX_DIGITS)
                begin
                    new_digits = weight_idx;
                    new_frac = base_frac + frac_add;
                end
            end
            else
            begin
                new_int = (int_wide > INT_CAP) ? INT_CAP[INT_BITS-1:0] : int_wide[INT_BITS-1:0];
                new_mode = MODE_INT;
            end
        end
        else if (text_byte == CHAR_DOT)
        begin
            new_mode = MODE_FRAC;
        end
        else if (text_byte == CHAR_MINUS)
        begin
            new_negative = 1'b1;
            new_mode = MODE_SIGN;
        end
        else
        begin
            new_mode = MODE_NAN;
        end
    end

endmodule

`default_nettype wire

>>> sv/dtfp_value.sv
// finished token to saturated two's complement fixed point
`timescale 1ns / 1ps
`default_nettype none

module dtfp_value #(
    parameter int INT_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  dtfp_pkg::token_mode_t   mode,
    input  logic                    negative,
    input  logic [INT_BITS-1:0]     int_acc,
    input  logic [FRAC_BITS+3:0]    frac_acc,
    output logic signed [31:0]      value,
    output logic                    is_nan
);
    import dtfp_pkg::*;

    localparam int MW = INT_BITS + FRAC_BITS + 4;
    localparam int CW = (MW > 64) ? MW : 64;
    localparam logic [63:0] LIM = 64'd1 << (INT_BITS + FRAC_BITS - 1);
    localparam logic [63:0] POS_CAP = ((LIM - 64'd1) < 64'h7FFF_FFFF) ? (LIM - 64'd1)
                                                                    : 64'h7FFF_FFFF;
    localparam logic [63:0] NEG_CAP = (LIM < 64'h8000_0000) ? LIM : 64'h8000_0000;

    logic [MW-1:0] mag;
    logic [CW-1:0] mag_w;
    logic [CW-1:0] cap_w;
    logic [31:0]   mag_sat;

    always_comb
    begin
        mag = MW'({int_acc, {FRAC_BITS{1'b0}}}) + MW'(frac_acc);
        mag_w = CW'(mag);
        cap_w = negative ? CW'(NEG_CAP) : CW'(POS_CAP);
        mag_sat = (mag_w > cap_w) ? cap_w[31:0] : mag_w[31:0];
        is_nan = (mode == MODE_NAN);
        if (is_nan)
        begin
            value = '0;
        end
        else if (negative)
        begin
            value = signed'(32'd0 - mag_sat);
        end
        else
        begin
            value = signed'(mag_sat);
        end
    end

endmodule

`default_nettype wire

>>> sv/decimal_text_to_fixed_point_core.sv
// top level of the decimal text to fixed point parser
`timescale 1ns / 1ps
`default_nettype none

// Parses lines of space-separated decimal numbers, one text byte per transfer, into
// signed fixed point with FRAC_BITS fraction bits, tagged with row, column and line marks.
// One byte is taken every cycle unless a stalled result holds it; a byte enters the input
// register, then its result, if any, the result register. The path that sets the clock is
// the per-byte token update: multiply by ten with saturation or one weight-table add, then
// the saturating conversion of the finished token. A stalled result holds the input
// register and stalls the input if it is full. The user must write numbers_per_line via
// cfg_write and cfg_data only with no transfer in flight; the block does not enforce this.

module decimal_text_to_fixed_point_core #(
    parameter int INT_BITS = 16,
    parameter int FRAC_BITS = 16,
    parameter int MAX_FRAC_DIGITS = 9
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  dtfp_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output dtfp_pkg::out_item_t                  out_item,
    input  logic                                 cfg_write,
    input  logic [dtfp_pkg::COUNT_W-1:0]         cfg_data
);
    import dtfp_pkg::*;

    localparam int FW = FRAC_BITS + 4;

    // configuration
    logic [COUNT_W-1:0] npl_reg;

    // input stage
    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;

    // token and line state
    token_mode_t             mode_reg, mode_next;
    logic                    negative_reg, negative_next;
    logic [INT_BITS-1:0]     int_reg, int_next;
    logic [FW-1:0]           frac_reg, frac_next;
    logic [DIGIT_CNT_W-1:0]  digits_reg, digits_next;
    logic [COUNT_W-1:0]      col_reg, col_next;
    logic [COUNT_W-1:0]      row_reg, row_next;
    logic                    line_full_reg, line_full_next;

    // result stage
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;

    // token update and conversion
    logic                    cont;
    logic                    start;
    token_mode_t             app_mode;
    logic                    app_negative;
    logic [INT_BITS-1:0]     app_int;
    logic [FW-1:0]           app_frac;
    logic [DIGIT_CNT_W-1:0]  app_digits;

    token_mode_t             emit_mode;
    logic                    emit_negative;
    logic [INT_BITS-1:0]     emit_int;
    logic [FW-1:0]           emit_frac;
    logic signed [31:0]      emit_value;
    logic                    emit_is_nan;

    logic                    advance;
    logic                    eol;
    logic                    is_idle;
    logic                    full0;
    logic                    full1;
    logic [COUNT_W-1:0]      col_inc;
    logic                    reach;
    logic                    emit;
    logic                    emit_applied;
    logic                    filler;
    logic                    keep_token;

    dtfp_apply #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_apply (
        .cur_mode     (mode_reg),
        .cur_negative (negative_reg),
        .cur_int      (int_reg),
        .cur_frac     (frac_reg),
        .cur_digits   (digits_reg),
        .text_byte    (in_item_reg.text_byte),
        .cont         (cont),
        .start        (start),
        .new_mode     (app_mode),
        .new_negative (app_negative),
        .new_int      (app_int),
        .new_frac     (app_frac),
        .new_digits   (app_digits)
    );

    dtfp_value #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_value (
        .mode     (emit_mode),
        .negative (emit_negative),
        .int_acc  (emit_int),
        .frac_acc (emit_frac),
        .value    (emit_value),
        .is_nan   (emit_is_nan)
    );

    assign advance = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

    always_comb
    begin
        eol = in_item_reg.line_end;
        is_idle = (mode_reg == MODE_IDLE);
        full0 = line_full_reg || (col_reg >= npl_reg);
        col_inc = col_reg + COUNT_W'(1);
        reach = (col_inc >= npl_reg);

        // old token ended by this byte and filling the line, so no room is left for a new one
        full1 = !is_idle && !cont && reach;
        emit = !full0 && ((cont && eol) || (!is_idle && !cont) || (is_idle && start && eol));
        emit_applied = cont || is_idle;
        filler = !full0 && eol && is_idle && !start;
        keep_token = !full0 && !eol && (cont || (!full1 && start));

        emit_mode = emit_applied ? app_mode : mode_reg;
        emit_negative = emit_applied ? app_negative : negative_reg;
        emit_int = emit_applied ? app_int : int_reg;
        emit_frac = emit_applied ? app_frac : frac_reg;

        in_valid_next = in_valid_reg;
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        mode_next = mode_reg;
        negative_next = negative_reg;
        int_next = int_reg;
        frac_next = frac_reg;
        digits_next = digits_reg;
        col_next = col_reg;
        row_next = row_reg;
        line_full_next = line_full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next = out_item_reg;

        if (advance)
        begin
            if (keep_token)
            begin
                mode_next = app_mode;
                negative_next = app_negative;
                int_next = app_int;
                frac_next = app_frac;
                digits_next = app_digits;
            end
            else
            begin
                mode_next = MODE_IDLE;
                negative_next = 1'b0;
                int_next = '0;
                frac_next = '0;
                digits_next = '0;
            end

            out_item_next.row = row_reg;
            out_item_next.column = col_reg;
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_item_next.value = emit_value;
                out_item_next.is_nan = emit_is_nan;
                out_item_next.last_in_line = reach || eol;
                out_item_next.short_line = !reach && eol;
                col_next = col_inc;
                if (reach)
                begin
                    line_full_next = 1'b1;
                end
            end
            else if (filler)
            begin
                out_valid_next = 1'b1;
                out_item_next.value = '0;
                out_item_next.is_nan = 1'b0;
                out_item_next.last_in_line = 1'b1;
                out_item_next.short_line = 1'b1;
            end

            if (eol)
            begin
                col_next = '0;
                line_full_next = 1'b0;
                row_next = row_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npl_reg <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            npl_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg <= MODE_IDLE;
            negative_reg <= 1'b0;
            int_reg <= '0;
            frac_reg <= '0;
            digits_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            line_full_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg <= mode_next;
            negative_reg <= negative_next;
            int_reg <= int_next;
            frac_reg <= frac_next;
            digits_reg <= digits_next;
            col_reg <= col_next;
            row_reg <= row_next;
            line_full_reg <= line_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        out_item_reg <= out_item_next;
    end

    // a stall on the input only ever comes from a waiting result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a waiting result");

    // every processed byte that yields a result shows it on the next edge
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (emit || filler)) |=> out_valid)
        else $error("result of a transfer not presented");

    // a line end leaves no token open
    a_line_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.line_end) |=> (mode_reg == MODE_IDLE && col_reg == '0))
        else $error("token or column left over after line end");

    // a full line always has at least one number counted
    a_full_has_column: assert property (@(posedge clk) disable iff (!rst_n)
        line_full_reg |-> (col_reg != '0))
        else $error("line marked full with no numbers");

    // a short line mark only comes with the final result of a line
    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_item.short_line || out_item.last_in_line))
        else $error("short line mark without last mark");

endmodule

`default_nettype wire
